### rtl/core/rwl_pkg.sv
// Shared widths, codes and item types of the reader-writer lock unit.
`timescale 1ns / 1ps

package rwl_pkg;

    localparam int NUM_WORKERS = 16;
    localparam int ID_BITS     = 4;
    localparam int READER_BITS = 16;
    localparam int NEST_BITS   = 8;
    localparam int PEND_BITS   = 5;
    localparam int OP_BITS     = 2;
    localparam int STAT_BITS   = 2;

    localparam int IN_BITS     = OP_BITS + ID_BITS;
    localparam int IN_BYTES    = (IN_BITS + 7) / 8;
    localparam int IN_DATA_W   = IN_BYTES * 8;
    localparam int OUT_BITS    = STAT_BITS + ID_BITS + READER_BITS + PEND_BITS;
    localparam int OUT_BYTES   = (OUT_BITS + 7) / 8;
    localparam int OUT_DATA_W  = OUT_BYTES * 8;

    typedef enum logic [OP_BITS-1:0] {
        OP_WRITE_LOCK   = 2'd0,
        OP_WRITE_UNLOCK = 2'd1,
        OP_READ_LOCK    = 2'd2,
        OP_READ_UNLOCK  = 2'd3
    } t_op;

    typedef enum logic [STAT_BITS-1:0] {
        ST_OK   = 2'd0,
        ST_BUSY = 2'd1,
        ST_ERR  = 2'd2
    } t_status;

    typedef struct packed {
        logic [ID_BITS-1:0] worker_id;
        t_op                operation;
    } t_item;

    typedef struct packed {
        logic [PEND_BITS-1:0]   waiting_writers;
        logic [READER_BITS-1:0] readers_now;
        logic [ID_BITS-1:0]     owner_now;
        t_status                status;
    } t_result;

endpackage

### rtl/core/rwl_in_stage.sv
// Input register stage that holds one lock request item.
`timescale 1ns / 1ps

module rwl_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  rwl_pkg::t_item i_item,
    input  logic           i_advance,
    output logic           o_valid,
    output rwl_pkg::t_item o_item
);
    import rwl_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

### rtl/core/rwl_state.sv
// Lock state registers and the single-pass request evaluation.
`timescale 1ns / 1ps

module rwl_state (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rwl_pkg::t_item   i_item,
    input  logic             i_advance,
    output rwl_pkg::t_result o_result
);
    import rwl_pkg::*;

    localparam logic [PEND_BITS-1:0]   PEND_ONE = PEND_BITS'(1);
    localparam logic [READER_BITS-1:0] RD_ONE   = READER_BITS'(1);
    localparam logic [READER_BITS-1:0] RD_MAX   = '1;
    localparam logic [NEST_BITS-1:0]   NEST_ONE = NEST_BITS'(1);
    localparam logic [NEST_BITS-1:0]   NEST_MAX = '1;
    localparam logic [ID_BITS:0]       ID_LIMIT = (ID_BITS+1)'(NUM_WORKERS);

    logic [ID_BITS-1:0]     r_owner,      n_owner;
    logic [READER_BITS-1:0] r_readers,    n_readers;
    logic [PEND_BITS-1:0]   r_pend_total, n_pend_total;
    logic [NUM_WORKERS-1:0] r_pend_mark,  n_pend_mark;
    logic [NEST_BITS-1:0]   r_wr_nest,    n_wr_nest;
    logic [NEST_BITS-1:0]   r_rd_nest,    n_rd_nest;
    t_status                status;
    logic                   id_ok;
    logic                   is_owner;
    logic [ID_BITS-1:0]     id;

    assign id       = i_item.worker_id;
    assign id_ok    = (id != '0) && ({1'b0, id} < ID_LIMIT);
    assign is_owner = (r_owner == id);

    always_comb begin
        n_owner      = r_owner;
        n_readers    = r_readers;
        n_pend_total = r_pend_total;
        n_pend_mark  = r_pend_mark;
        n_wr_nest    = r_wr_nest;
        n_rd_nest    = r_rd_nest;
        status       = ST_OK;
        if (!id_ok) begin
            status = ST_ERR;
        end else begin
            case (i_item.operation)
                OP_WRITE_LOCK: begin
                    if (is_owner) begin
                        if (r_wr_nest == NEST_MAX) begin
                            status = ST_ERR;
                        end else begin
                            n_wr_nest = r_wr_nest + NEST_ONE;
                        end
                    end else if (r_owner == '0 && r_readers == '0) begin
                        n_owner   = id;
                        n_wr_nest = NEST_ONE;
                        n_rd_nest = '0;
                        if (r_pend_mark[id]) begin
                            n_pend_mark[id] = 1'b0;
                            if (r_pend_total != '0) begin
                                n_pend_total = r_pend_total - PEND_ONE;
                            end
                        end
                    end else begin
                        status = ST_BUSY;
                        if (!r_pend_mark[id]) begin
                            n_pend_mark[id] = 1'b1;
                            n_pend_total    = r_pend_total + PEND_ONE;
                        end
                    end
                end
                OP_WRITE_UNLOCK: begin
                    if (!is_owner) begin
                        status = ST_ERR;
                    end else if (r_wr_nest <= NEST_ONE) begin
                        n_wr_nest = '0;
                        n_owner   = '0;
                        n_rd_nest = '0;
                    end else begin
                        n_wr_nest = r_wr_nest - NEST_ONE;
                    end
                end
                OP_READ_LOCK: begin
                    if (is_owner) begin
                        if (r_rd_nest == NEST_MAX) begin
                            status = ST_ERR;
                        end else begin
                            n_rd_nest = r_rd_nest + NEST_ONE;
                        end
                    end else if (r_owner != '0 || r_pend_total != '0) begin
                        status = ST_BUSY;
                    end else if (r_readers == RD_MAX) begin
                        status = ST_ERR;
                    end else begin
                        n_readers = r_readers + RD_ONE;
                    end
                end
                OP_READ_UNLOCK: begin
                    if (is_owner) begin
                        if (r_rd_nest == '0) begin
                            status = ST_ERR;
                        end else begin
                            n_rd_nest = r_rd_nest - NEST_ONE;
                        end
                    end else if (r_readers == '0) begin
                        status = ST_ERR;
                    end else begin
                        n_readers = r_readers - RD_ONE;
                    end
                end
                default: begin
                    status = ST_ERR;
                end
            endcase
        end
    end

    assign o_result.status          = status;
    assign o_result.owner_now       = n_owner;
    assign o_result.readers_now     = n_readers;
    assign o_result.waiting_writers = n_pend_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner      <= '0;
            r_readers    <= '0;
            r_pend_total <= '0;
            r_pend_mark  <= '0;
            r_wr_nest    <= '0;
            r_rd_nest    <= '0;
        end else if (i_advance) begin
            r_owner      <= n_owner;
            r_readers    <= n_readers;
            r_pend_total <= n_pend_total;
            r_pend_mark  <= n_pend_mark;
            r_wr_nest    <= n_wr_nest;
            r_rd_nest    <= n_rd_nest;
        end
    end

    a_owner_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_owner != '0) == (r_wr_nest != '0))
        else $error("owner and write depth disagree");

    a_pend_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        PEND_BITS'($countones(r_pend_mark)) == r_pend_total)
        else $error("pending count does not match pending marks");

    a_owner_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_owner != '0 |-> r_readers == '0)
        else $error("shared readers present while a writer owns the lock");

    a_rd_nest_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_owner == '0 |-> r_rd_nest == '0)
        else $error("owner read depth left without an owner");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_advance |=> $stable(r_owner) && $stable(r_readers) && $stable(r_pend_mark))
        else $error("lock state changed without an item");

endmodule

### rtl/core/rwl_out_stage.sv
// Result register stage that holds one result item until taken.
`timescale 1ns / 1ps

module rwl_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  rwl_pkg::t_result i_result,
    output logic             o_valid,
    input  logic             i_ready,
    output rwl_pkg::t_result o_result
);
    import rwl_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end

endmodule

### rtl/core/reader_writer_lock_unit.sv
// Top level of the reader-writer lock unit with writer preference.
`timescale 1ns / 1ps

// Takes one lock request item per clock while the result side takes results, and
// returns one result item for each: the request sits in an input register, the lock
// state (owner, reader count, pending writers, nesting depths) is evaluated and
// updated in one pass, and the answer lands in a result register. The single-pass
// update of the lock state sets the rate of one item per cycle; a stalled
// result side holds both stages without losing items.
module reader_writer_lock_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [1:0] operation, [5:2] worker_id, zero fill above
    input  logic [rwl_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [1:0] status, [5:2] owner_now, [21:6] readers_now,
    // [26:22] waiting_writers, zero fill above
    output logic [rwl_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata
);
    import rwl_pkg::*;

    t_item   in_item;
    t_item   held_item;
    t_result calc_result;
    t_result out_result;
    logic    held_valid;
    logic    out_ready;
    logic    advance;

    assign in_item = t_item'(i_s_axis_tdata[IN_BITS-1:0]);
    assign advance = held_valid && out_ready;

    rwl_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    rwl_state u_state (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (held_item),
        .i_advance (advance),
        .o_result  (calc_result)
    );

    rwl_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (held_valid),
        .o_ready  (out_ready),
        .i_result (calc_result),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (out_result)
    );

    assign o_m_axis_tdata = {{(OUT_DATA_W-OUT_BITS){1'b0}}, out_result};

endmodule

### sim/tb_reader_writer_lock_unit.sv
// Self-checking testbench of the reader-writer lock unit with a lock-state predictor.
`timescale 1ns / 1ps

module tb_reader_writer_lock_unit;
    import rwl_pkg::*;

    localparam int RANDOM_ITEMS = 800;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int PRINT_CAP    = 20;

    typedef struct packed {
        logic [ID_BITS-1:0]     owner;
        logic [READER_BITS-1:0] readers;
        logic [PEND_BITS-1:0]   pend_total;
        logic [NUM_WORKERS-1:0] pend_mark;
        logic [NEST_BITS-1:0]   wnest;
        logic [NEST_BITS-1:0]   rnest;
    } t_lock_state;

    typedef struct packed {
        t_lock_state st;
        t_status     status;
    } t_lock_step;

    typedef struct packed {
        logic  drain;
        t_item it;
    } t_request;

    logic                  i_clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_ready = 1'b0;
    logic                  s_ready;
    logic                  m_valid;
    logic [OUT_DATA_W-1:0] m_tdata;

    t_request    request_q[$];
    t_result     lock_answer_q[$];
    t_lock_state plan_st = '0;
    t_lock_state lock_st = '0;
    t_status     plan_status;

    int queued = 0;
    int accepted = 0;
    int checked = 0;
    int err_count = 0;
    int n_ok = 0;
    int n_busy = 0;
    int n_err = 0;
    int peak_readers = 0;
    int peak_pending = 0;
    int peak_wnest = 0;
    int cycle_count = 0;
    int gap_left = 0;
    int send_calm = 0;
    int stall_left = 0;
    int recv_calm = 0;

    reader_writer_lock_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_tdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;
    end

    function automatic t_lock_step rwl_next(t_lock_state s, t_item it);
        t_lock_step         r;
        logic [ID_BITS-1:0] id;
        r.st = s;
        r.status = ST_OK;
        id = it.worker_id;
        if (id == '0) begin
            r.status = ST_ERR;
        end else begin
            case (it.operation)
                OP_WRITE_LOCK: begin
                    if (s.owner == id) begin
                        if (s.wnest == '1) r.status = ST_ERR;
                        else r.st.wnest = s.wnest + 1'b1;
                    end else if (s.owner == '0 && s.readers == '0) begin
                        r.st.owner = id;
                        r.st.wnest = NEST_BITS'(1);
                        r.st.rnest = '0;
                        if (s.pend_mark[id]) begin
                            r.st.pend_mark[id] = 1'b0;
                            if (s.pend_total != '0) r.st.pend_total = s.pend_total - 1'b1;
                        end
                    end else begin
                        if (!s.pend_mark[id]) begin
                            r.st.pend_mark[id] = 1'b1;
                            r.st.pend_total = s.pend_total + 1'b1;
                        end
                        r.status = ST_BUSY;
                    end
                end
                OP_WRITE_UNLOCK: begin
                    if (s.owner != id) begin
                        r.status = ST_ERR;
                    end else if (s.wnest <= NEST_BITS'(1)) begin
                        r.st.wnest = '0;
                        r.st.owner = '0;
                        r.st.rnest = '0;
                    end else begin
                        r.st.wnest = s.wnest - 1'b1;
                    end
                end
                OP_READ_LOCK: begin
                    if (s.owner == id) begin
                        if (s.rnest == '1) r.status = ST_ERR;
                        else r.st.rnest = s.rnest + 1'b1;
                    end else if (s.owner != '0 || s.pend_total != '0) begin
                        r.status = ST_BUSY;
                    end else if (s.readers == '1) begin
                        r.status = ST_ERR;
                    end else begin
                        r.st.readers = s.readers + 1'b1;
                    end
                end
                OP_READ_UNLOCK: begin
                    if (s.owner == id) begin
                        if (s.rnest == '0) r.status = ST_ERR;
                        else r.st.rnest = s.rnest - 1'b1;
                    end else if (s.readers == '0) begin
                        r.status = ST_ERR;
                    end else begin
                        r.st.readers = s.readers - 1'b1;
                    end
                end
                default: begin
                    r.status = ST_ERR;
                end
            endcase
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 6);
        return $urandom_range(10, 30);
    endfunction

    function automatic logic [ID_BITS-1:0] pick_worker();
        if ($urandom_range(0, 3) != 0) return ID_BITS'($urandom_range(1, 4));
        return ID_BITS'($urandom_range(1, NUM_WORKERS - 1));
    endfunction

    function automatic logic [ID_BITS-1:0] pick_non_owner();
        logic [ID_BITS-1:0] r;
        r = pick_worker();
        if (r == plan_st.owner) r = (r == ID_BITS'(NUM_WORKERS - 1)) ? ID_BITS'(1) : r + 1'b1;
        return r;
    endfunction

    function automatic logic [ID_BITS-1:0] pick_writer();
        logic [ID_BITS-1:0] r;
        r = pick_worker();
        if (plan_st.pend_mark != '0 && $urandom_range(0, 1) == 0) begin
            r = ID_BITS'($urandom_range(1, NUM_WORKERS - 1));
            while (!plan_st.pend_mark[r]) r = ID_BITS'($urandom_range(1, NUM_WORKERS - 1));
        end
        return r;
    endfunction

    task automatic queue_req(input t_op op, input logic [ID_BITS-1:0] id, input bit drain);
        t_request   r;
        t_lock_step s;
        r.drain = drain;
        r.it.operation = op;
        r.it.worker_id = id;
        request_q.push_back(r);
        s = rwl_next(plan_st, r.it);
        plan_st = s.st;
        plan_status = s.status;
        queued++;
    endtask

    task automatic release_owner();
        while (plan_st.owner != '0) queue_req(OP_WRITE_UNLOCK, plan_st.owner, 1'b0);
    endtask

    task automatic release_all();
        release_owner();
        while (plan_st.readers != '0) queue_req(OP_READ_UNLOCK, pick_worker(), 1'b0);
        for (int w = 1; w < NUM_WORKERS; w++) begin
            if (plan_st.pend_mark[w]) begin
                queue_req(OP_WRITE_LOCK, ID_BITS'(w), 1'b0);
                queue_req(OP_WRITE_UNLOCK, ID_BITS'(w), 1'b0);
            end
        end
    endtask

    task automatic writer_session();
        logic [ID_BITS-1:0] w;
        logic [ID_BITS-1:0] other;
        w = pick_writer();
        queue_req(OP_WRITE_LOCK, w, $urandom_range(0, 59) == 0);
        repeat ($urandom_range(0, 6)) begin
            other = pick_worker();
            case ($urandom_range(0, 5))
                0: queue_req(OP_WRITE_LOCK, w, 1'b0);
                1: queue_req(OP_READ_LOCK, w, 1'b0);
                2: queue_req(OP_READ_UNLOCK, w, 1'b0);
                3: queue_req(OP_READ_LOCK, other, 1'b0);
                4: queue_req(OP_WRITE_LOCK, other, 1'b0);
                default: queue_req(OP_WRITE_UNLOCK, w, 1'b0);
            endcase
        end
        if ($urandom_range(0, 9) != 0) release_owner();
    endtask

    task automatic reader_session();
        logic [ID_BITS-1:0] r;
        int                 held;
        held = 0;
        repeat ($urandom_range(1, 5)) begin
            r = pick_worker();
            queue_req(OP_READ_LOCK, r, $urandom_range(0, 59) == 0);
            if (plan_status == ST_OK && plan_st.owner != r) held++;
        end
        held = held - int'($urandom_range(0, 1));
        for (int i = 0; i < held; i++) queue_req(OP_READ_UNLOCK, pick_non_owner(), 1'b0);
    endtask

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        if (err_count < PRINT_CAP) begin
            $display("mismatch at result %0d: %s got %0h expected %0h",
                     checked, what, got_v, want_v);
        end
        err_count++;
    endtask

    // driver: present queued requests, predict each accepted item
    always @(posedge i_clk) begin : drive
        t_request             nxt;
        t_lock_step           stp;
        t_result              ans;
        logic [IN_DATA_W-1:0] word;
        logic                 vld_n;
        if (!rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            vld_n = 1'b0;
            if (s_valid) begin
                stp = rwl_next(lock_st, t_item'(s_tdata[IN_BITS-1:0]));
                lock_st = stp.st;
                ans.status = stp.status;
                ans.owner_now = stp.st.owner;
                ans.readers_now = stp.st.readers;
                ans.waiting_writers = stp.st.pend_total;
                lock_answer_q.push_back(ans);
                accepted++;
                case (stp.status)
                    ST_OK:   n_ok++;
                    ST_BUSY: n_busy++;
                    default: n_err++;
                endcase
                if (stp.st.readers > peak_readers) peak_readers = stp.st.readers;
                if (stp.st.pend_total > peak_pending) peak_pending = stp.st.pend_total;
                if (stp.st.wnest > peak_wnest) peak_wnest = stp.st.wnest;
            end
            if (gap_left > 0) begin
                gap_left--;
            end else if (request_q.size() != 0 &&
                         !(request_q[0].drain && lock_answer_q.size() != 0)) begin
                nxt = request_q.pop_front();
                word = '0;
                word[IN_BITS-1:0] = nxt.it;
                s_tdata <= word;
                vld_n = 1'b1;
                if (send_calm > 0) begin
                    send_calm--;
                end else begin
                    gap_left = pick_gap();
                    if ($urandom_range(0, 49) == 0) send_calm = $urandom_range(30, 120);
                end
            end
            s_valid <= vld_n;
        end
    end

    // monitor: compare each result item with the oldest prediction
    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        logic    rdy_n;
        if (rst_n && m_ready && m_valid) begin
            got = t_result'(m_tdata[OUT_BITS-1:0]);
            if (lock_answer_q.size() == 0) begin
                report_mismatch("result with nothing pending", int'(got), 0);
            end else begin
                want = lock_answer_q.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.owner_now != want.owner_now)
                    report_mismatch("owner_now", got.owner_now, want.owner_now);
                if (got.readers_now != want.readers_now)
                    report_mismatch("readers_now", got.readers_now, want.readers_now);
                if (got.waiting_writers != want.waiting_writers)
                    report_mismatch("waiting_writers", got.waiting_writers,
                                    want.waiting_writers);
                checked++;
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            rdy_n = 1'b0;
        end else begin
            rdy_n = 1'b1;
            if (recv_calm > 0) begin
                recv_calm--;
            end else if ($urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
            end else if ($urandom_range(0, 59) == 0) begin
                recv_calm = $urandom_range(30, 120);
            end
        end
        m_ready <= rdy_n;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, lock_answer_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        logic [ID_BITS-1:0] w;
        int                 start;

        // directed: invalid worker, busy and pending marks, bad unlocks, nesting
        queue_req(OP_WRITE_LOCK, 0, 1'b0);
        queue_req(OP_READ_UNLOCK, 15, 1'b0);
        queue_req(OP_READ_LOCK, 15, 1'b0);
        queue_req(OP_WRITE_LOCK, 3, 1'b0);
        queue_req(OP_WRITE_LOCK, 3, 1'b0);
        queue_req(OP_READ_LOCK, 7, 1'b0);
        queue_req(OP_WRITE_UNLOCK, 3, 1'b0);
        queue_req(OP_READ_UNLOCK, 15, 1'b0);
        queue_req(OP_WRITE_LOCK, 3, 1'b0);
        queue_req(OP_READ_UNLOCK, 3, 1'b0);
        queue_req(OP_READ_LOCK, 3, 1'b0);
        queue_req(OP_WRITE_LOCK, 3, 1'b0);
        queue_req(OP_WRITE_LOCK, 9, 1'b0);
        queue_req(OP_READ_LOCK, 1, 1'b0);
        queue_req(OP_WRITE_UNLOCK, 9, 1'b0);
        queue_req(OP_WRITE_UNLOCK, 3, 1'b0);
        queue_req(OP_READ_LOCK, 3, 1'b0);
        queue_req(OP_WRITE_UNLOCK, 3, 1'b0);
        queue_req(OP_READ_UNLOCK, 3, 1'b0);
        queue_req(OP_WRITE_LOCK, 9, 1'b0);
        queue_req(OP_WRITE_UNLOCK, 9, 1'b0);
        queue_req(OP_READ_LOCK, 0, 1'b0);
        queue_req(OP_READ_UNLOCK, 0, 1'b0);
        queue_req(OP_WRITE_UNLOCK, 0, 1'b0);

        // drive write and read nesting of one owner past their limits
        release_all();
        w = ID_BITS'($urandom_range(1, NUM_WORKERS - 1));
        queue_req(OP_WRITE_LOCK, w, 1'b1);
        while (plan_st.wnest != '1) queue_req(OP_WRITE_LOCK, w, 1'b0);
        queue_req(OP_WRITE_LOCK, w, 1'b0);
        while (plan_st.rnest != '1) queue_req(OP_READ_LOCK, w, 1'b0);
        queue_req(OP_READ_LOCK, w, 1'b0);
        while (plan_st.rnest != '0) queue_req(OP_READ_UNLOCK, w, 1'b0);
        queue_req(OP_READ_UNLOCK, w, 1'b0);
        release_owner();

        start = queued;
        while (queued - start < RANDOM_ITEMS) begin
            case ($urandom_range(0, 99)) inside
                [0:29]:  writer_session();
                [30:59]: reader_session();
                [60:69]: begin
                    repeat ($urandom_range(1, 20)) begin
                        if (plan_st.readers != '0)
                            queue_req(OP_READ_UNLOCK, pick_non_owner(), 1'b0);
                    end
                end
                [70:79]: begin
                    repeat ($urandom_range(1, 4)) queue_req(OP_WRITE_LOCK, pick_worker(), 1'b0);
                    queue_req(OP_READ_LOCK, pick_worker(), 1'b0);
                end
                [80:84]: release_all();
                default: begin
                    repeat ($urandom_range(1, 4))
                        queue_req(t_op'($urandom_range(0, 3)),
                                  ID_BITS'($urandom_range(0, 15)), 1'b0);
                end
            endcase
        end

        while (request_q.size() != 0 || s_valid) @(posedge i_clk);
        while (lock_answer_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("%0d requests sent, %0d results checked: %0d granted or done, %0d busy, %0d errors",
                 accepted, checked, n_ok, n_busy, n_err);
        $display("peak shared readers %0d, peak pending writers %0d, deepest write nesting %0d",
                 peak_readers, peak_pending, peak_wnest);
        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/rwl_pkg.sv
rtl/core/rwl_in_stage.sv
rtl/core/rwl_state.sv
rtl/core/rwl_out_stage.sv
rtl/core/reader_writer_lock_unit.sv
sim/tb_reader_writer_lock_unit.sv
